>>> sv/irpd_pkg.sv
// shared constants and types for the ir pulse-distance byte decoder
package irpd_pkg;

    localparam int DATA_BITS_DEFAULT   = 8;
    localparam int STAMP_WIDTH_DEFAULT = 16;

    localparam int TIME_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int SYMBOL_W   = 2;
    localparam int CFG_INDEX_W = 3;

    localparam logic [SYMBOL_W-1:0] SYM_START = 2'd0;
    localparam logic [SYMBOL_W-1:0] SYM_ZERO  = 2'd1;
    localparam logic [SYMBOL_W-1:0] SYM_ONE   = 2'd2;
    localparam logic [SYMBOL_W-1:0] SYM_ERROR = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_START_MIN = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_MAX = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_MIN  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_MAX  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_MIN   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_MAX   = 3'd5;

    localparam logic [TIME_W-1:0] START_MIN_RESET = 16'd56000;
    localparam logic [TIME_W-1:0] START_MAX_RESET = 16'd64000;
    localparam logic [TIME_W-1:0] ZERO_MIN_RESET  = 16'd20000;
    localparam logic [TIME_W-1:0] ZERO_MAX_RESET  = 16'd28000;
    localparam logic [TIME_W-1:0] ONE_MIN_RESET   = 16'd32000;
    localparam logic [TIME_W-1:0] ONE_MAX_RESET   = 16'd40000;

    typedef struct packed {
        logic [TIME_W-1:0] start_min;
        logic [TIME_W-1:0] start_max;
        logic [TIME_W-1:0] zero_min;
        logic [TIME_W-1:0] zero_max;
        logic [TIME_W-1:0] one_min;
        logic [TIME_W-1:0] one_max;
    } irpd_windows_t;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                led_on;
        logic                byte_done;
        logic [BYTE_W-1:0]   data_byte;
        logic [TIME_W-1:0]   interval;
    } irpd_result_t;

endpackage

>>> sv/irpd_window_regs.sv
// window bound registers written through the configuration port
module irpd_window_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [irpd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [irpd_pkg::TIME_W-1:0]          cfg_data,
    output irpd_pkg::irpd_windows_t              windows
);

    irpd_pkg::irpd_windows_t windows_reg;
    irpd_pkg::irpd_windows_t windows_next;

    always_comb
    begin
        windows_next = windows_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                irpd_pkg::REG_START_MIN: windows_next.start_min = cfg_data;
                irpd_pkg::REG_START_MAX: windows_next.start_max = cfg_data;
                irpd_pkg::REG_ZERO_MIN:  windows_next.zero_min  = cfg_data;
                irpd_pkg::REG_ZERO_MAX:  windows_next.zero_max  = cfg_data;
                irpd_pkg::REG_ONE_MIN:   windows_next.one_min   = cfg_data;
                irpd_pkg::REG_ONE_MAX:   windows_next.one_max   = cfg_data;
                default:                 windows_next = windows_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            windows_reg.start_min <= irpd_pkg::START_MIN_RESET;
            windows_reg.start_max <= irpd_pkg::START_MAX_RESET;
            windows_reg.zero_min  <= irpd_pkg::ZERO_MIN_RESET;
            windows_reg.zero_max  <= irpd_pkg::ZERO_MAX_RESET;
            windows_reg.one_min   <= irpd_pkg::ONE_MIN_RESET;
            windows_reg.one_max   <= irpd_pkg::ONE_MAX_RESET;
        end
        else
        begin
            windows_reg <= windows_next;
        end
    end

    assign windows = windows_reg;

endmodule

>>> sv/irpd_classify.sv
// sorts an interval into start, zero bit, one bit or error, first window wins
module irpd_classify #(
    parameter int STAMP_WIDTH = irpd_pkg::STAMP_WIDTH_DEFAULT
)
(
    input  logic [STAMP_WIDTH-1:0]            interval,
    input  irpd_pkg::irpd_windows_t           windows,
    output logic [irpd_pkg::SYMBOL_W-1:0]     symbol
);

    localparam int CW = (STAMP_WIDTH > irpd_pkg::TIME_W) ? STAMP_WIDTH : irpd_pkg::TIME_W;

    logic [CW-1:0] ivl_ext;
    logic          in_start;
    logic          in_zero;
    logic          in_one;

    always_comb
    begin
        ivl_ext = '0;
        for (int i = 0; i < STAMP_WIDTH; i++)
        begin
            ivl_ext[i] = interval[i];
        end
    end

    // inclusive bounds, an inverted window matches nothing
    assign in_start = (ivl_ext >= CW'(windows.start_min)) && (ivl_ext <= CW'(windows.start_max));
    assign in_zero  = (ivl_ext >= CW'(windows.zero_min))  && (ivl_ext <= CW'(windows.zero_max));
    assign in_one   = (ivl_ext >= CW'(windows.one_min))   && (ivl_ext <= CW'(windows.one_max));

    always_comb
    begin
        if (in_start)
        begin
            symbol = irpd_pkg::SYM_START;
        end
        else if (in_zero)
        begin
            symbol = irpd_pkg::SYM_ZERO;
        end
        else if (in_one)
        begin
            symbol = irpd_pkg::SYM_ONE;
        end
        else
        begin
            symbol = irpd_pkg::SYM_ERROR;
        end
    end

endmodule

>>> sv/irpd_frame.sv
// interval measurement and frame state: last stamp, bit count, byte under assembly
module irpd_frame #(
    parameter int DATA_BITS   = irpd_pkg::DATA_BITS_DEFAULT,
    parameter int STAMP_WIDTH = irpd_pkg::STAMP_WIDTH_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic [irpd_pkg::TIME_W-1:0]       capture_time,
    input  irpd_pkg::irpd_windows_t           windows,
    output irpd_pkg::irpd_result_t            result
);

    localparam int BW = $clog2(DATA_BITS + 1);
    localparam int PW = (BW > 4) ? BW : 4;

    logic [STAMP_WIDTH-1:0]        last_stamp_reg;
    logic [STAMP_WIDTH-1:0]        last_stamp_next;
    logic [BW-1:0]                 bits_left_reg;
    logic [BW-1:0]                 bits_left_next;
    logic [irpd_pkg::BYTE_W-1:0]   shift_byte_reg;
    logic [irpd_pkg::BYTE_W-1:0]   shift_byte_next;

    logic [STAMP_WIDTH-1:0]        stamp;
    logic [STAMP_WIDTH-1:0]        ivl;
    logic [irpd_pkg::SYMBOL_W-1:0] symbol;
    logic                          frame_open;
    logic                          is_data;
    logic                          last_bit;

    always_comb
    begin
        stamp = '0;
        for (int i = 0; i < STAMP_WIDTH; i++)
        begin
            if (i < irpd_pkg::TIME_W)
            begin
                stamp[i] = capture_time[i];
            end
        end
    end

    // wraps modulo 2^STAMP_WIDTH
    assign ivl = stamp - last_stamp_reg;

    irpd_classify #(
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_classify (
        .interval (ivl),
        .windows  (windows),
        .symbol   (symbol)
    );

    assign frame_open = (bits_left_reg != '0);
    assign is_data    = (symbol == irpd_pkg::SYM_ZERO) || (symbol == irpd_pkg::SYM_ONE);
    assign last_bit   = is_data && (bits_left_reg == BW'(1));

    always_comb
    begin
        last_stamp_next = stamp;
        bits_left_next  = bits_left_reg;
        shift_byte_next = shift_byte_reg;
        case (symbol)
            irpd_pkg::SYM_START:
            begin
                shift_byte_next = '0;
                bits_left_next  = BW'(DATA_BITS);
            end
            irpd_pkg::SYM_ZERO, irpd_pkg::SYM_ONE:
            begin
                // data bits outside a frame leave the bit count and byte alone
                if (frame_open)
                begin
                    bits_left_next = bits_left_reg - BW'(1);
                    for (int i = 0; i < irpd_pkg::BYTE_W; i++)
                    begin
                        if ((symbol == irpd_pkg::SYM_ONE) &&
                            (PW'(bits_left_reg) == PW'(i + 1)))
                        begin
                            shift_byte_next[i] = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                bits_left_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_stamp_reg <= '0;
            bits_left_reg  <= '0;
            shift_byte_reg <= '0;
        end
        else if (advance)
        begin
            last_stamp_reg <= last_stamp_next;
            bits_left_reg  <= bits_left_next;
            shift_byte_reg <= shift_byte_next;
        end
    end

    always_comb
    begin
        result.symbol    = symbol;
        result.byte_done = last_bit;
        result.data_byte = shift_byte_next;
        result.led_on    = ((symbol == irpd_pkg::SYM_START) ||
                            (symbol == irpd_pkg::SYM_ONE)) && !last_bit;
        result.interval  = '0;
        for (int i = 0; i < irpd_pkg::TIME_W; i++)
        begin
            if (i < STAMP_WIDTH)
            begin
                result.interval[i] = ivl[i];
            end
        end
    end

endmodule

>>> sv/ir_pulse_distance_byte_decoder.sv
// ir pulse-distance byte decoder: input register, decode logic, result register
// path: a stamp taken into the input register is decoded and then held in the result register
// throughput: one stamp per cycle while the output is not stalled, set by the single compare-and-update pass
// a stalled result holds while the input register can still take one more stamp
// reset: async active low, clears frame state, last stamp and valids, loads window defaults
module ir_pulse_distance_byte_decoder #(
    parameter int DATA_BITS   = irpd_pkg::DATA_BITS_DEFAULT,
    parameter int STAMP_WIDTH = irpd_pkg::STAMP_WIDTH_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [irpd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [irpd_pkg::TIME_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [irpd_pkg::TIME_W-1:0]          capture_time,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [irpd_pkg::SYMBOL_W-1:0]        symbol,
    output logic                                 led_on,
    output logic                                 byte_done,
    output logic [irpd_pkg::BYTE_W-1:0]          data_byte,
    output logic [irpd_pkg::TIME_W-1:0]          interval
);

    irpd_pkg::irpd_windows_t        windows;
    irpd_pkg::irpd_result_t         result;
    irpd_pkg::irpd_result_t         result_reg;

    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    logic [irpd_pkg::TIME_W-1:0]    capture_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           out_open;
    logic                           advance;
    logic                           in_take;

    irpd_window_regs u_window_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .windows   (windows)
    );

    irpd_frame #(
        .DATA_BITS   (DATA_BITS),
        .STAMP_WIDTH (STAMP_WIDTH)
    ) u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .capture_time (capture_reg),
        .windows      (windows),
        .result       (result)
    );

    assign out_open = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_open;
    assign in_stall = s1_valid_reg && !out_open;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next  = in_take || (s1_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            capture_reg <= capture_time;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = result_reg.symbol;
    assign led_on    = result_reg.led_on;
    assign byte_done = result_reg.byte_done;
    assign data_byte = result_reg.data_byte;
    assign interval  = result_reg.interval;

`ifndef SYNTHESIS
    // a finished byte only comes from a data bit, and it turns the led off
    a_done_is_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_done) |->
            ((symbol == irpd_pkg::SYM_ZERO) || (symbol == irpd_pkg::SYM_ONE)))
        else $error("byte_done on a non-data symbol");

    a_done_led_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_done) |-> !led_on)
        else $error("led lit on frame end");

    a_start_led_on: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (symbol == irpd_pkg::SYM_START)) |-> led_on)
        else $error("led dark on start");

    // the input side only backs up when both stages are full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipe");
`endif

endmodule

>>> sim/tb_ir_pulse_distance_byte_decoder.sv
// self-checking testbench for the ir pulse-distance byte decoder
`timescale 1ns / 100ps

module tb_ir_pulse_distance_byte_decoder;

    localparam int FRAME_BITS = irpd_pkg::DATA_BITS_DEFAULT;

    typedef logic [irpd_pkg::TIME_W-1:0] stamp_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [irpd_pkg::CFG_INDEX_W-1:0] cfg_index = irpd_pkg::REG_START_MIN;
    logic [irpd_pkg::TIME_W-1:0]      cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic [irpd_pkg::TIME_W-1:0]      capture_time = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [irpd_pkg::SYMBOL_W-1:0]    symbol;
    logic                             led_on;
    logic                             byte_done;
    logic [irpd_pkg::BYTE_W-1:0]      data_byte;
    logic [irpd_pkg::TIME_W-1:0]      interval;

    // stamps waiting for the driver, decoded edges waiting for the dut
    stamp_t                 stamps_to_send[$];
    irpd_pkg::irpd_result_t results_due[$];
    int unsigned            mismatches = 0;
    int unsigned            idle_pct = 8;

    // generator cursor
    stamp_t next_stamp = '0;

    // decoder mirror
    irpd_pkg::irpd_windows_t     win = '{irpd_pkg::START_MIN_RESET, irpd_pkg::START_MAX_RESET,
                                         irpd_pkg::ZERO_MIN_RESET, irpd_pkg::ZERO_MAX_RESET,
                                         irpd_pkg::ONE_MIN_RESET, irpd_pkg::ONE_MAX_RESET};
    stamp_t                      last_stamp = '0;
    logic [3:0]                  bits_left = '0;
    logic [irpd_pkg::BYTE_W-1:0] shift_byte = '0;

    ir_pulse_distance_byte_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .capture_time (capture_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .symbol       (symbol),
        .led_on       (led_on),
        .byte_done    (byte_done),
        .data_byte    (data_byte),
        .interval     (interval)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic in_win(stamp_t v, stamp_t lo, stamp_t hi);
        return v >= lo && v <= hi;
    endfunction

    // classify one edge and advance the frame state
    function automatic irpd_pkg::irpd_result_t decode_edge(stamp_t stamp);
        irpd_pkg::irpd_result_t r;
        logic                   is_data;
        logic                   data_bit;
        r.interval  = stamp - last_stamp;
        r.byte_done = 1'b0;
        last_stamp  = stamp;
        is_data     = 1'b0;
        data_bit    = 1'b0;
        if (in_win(r.interval, win.start_min, win.start_max))
        begin
            r.symbol   = irpd_pkg::SYM_START;
            r.led_on   = 1'b1;
            shift_byte = '0;
            bits_left  = 4'(FRAME_BITS);
        end
        else if (in_win(r.interval, win.zero_min, win.zero_max))
        begin
            r.symbol = irpd_pkg::SYM_ZERO;
            r.led_on = 1'b0;
            is_data  = 1'b1;
        end
        else if (in_win(r.interval, win.one_min, win.one_max))
        begin
            r.symbol = irpd_pkg::SYM_ONE;
            r.led_on = 1'b1;
            is_data  = 1'b1;
            data_bit = 1'b1;
        end
        else
        begin
            r.symbol  = irpd_pkg::SYM_ERROR;
            r.led_on  = 1'b0;
            bits_left = '0;
        end
        // a data bit outside a frame leaves the bit count and byte alone
        if (is_data && bits_left != 0)
        begin
            if (data_bit && bits_left <= irpd_pkg::BYTE_W)
                shift_byte[3'(bits_left - 4'd1)] = 1'b1;
            bits_left = bits_left - 4'd1;
            if (bits_left == 0)
            begin
                r.byte_done = 1'b1;
                r.led_on    = 1'b0;
            end
        end
        r.data_byte = shift_byte;
        return r;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                results_due.push_back(decode_edge(capture_time));
            if (!in_valid || !in_stall)
            begin
                if (stamps_to_send.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    in_valid     <= 1'b1;
                    capture_time <= stamps_to_send.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(string what, stamp_t want, stamp_t got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // monitor
    always @(posedge clk)
    begin : watch_results
        irpd_pkg::irpd_result_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, got symbol %0d interval %0d",
                             $time, symbol, interval);
                    mismatches++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("symbol", stamp_t'(want.symbol), stamp_t'(symbol));
                    check_field("led_on", stamp_t'(want.led_on), stamp_t'(led_on));
                    check_field("byte_done", stamp_t'(want.byte_done), stamp_t'(byte_done));
                    check_field("data_byte", stamp_t'(want.data_byte), stamp_t'(data_byte));
                    check_field("interval", want.interval, interval);
                end
            end
            out_stall <= $urandom_range(99) < idle_pct;
        end
    end

    task automatic queue_stamp(stamp_t stamp);
        next_stamp = stamp;
        stamps_to_send.push_back(stamp);
    endtask

    task automatic queue_gap(stamp_t gap);
        queue_stamp(next_stamp + gap);
    endtask

    // any value when the window is empty
    function automatic stamp_t pick(stamp_t lo, stamp_t hi);
        if (lo <= hi)
            return stamp_t'($urandom_range(hi, lo));
        return stamp_t'($urandom_range(16'hFFFF));
    endfunction

    task automatic drain();
        @(negedge clk);
        while (stamps_to_send.size() != 0 || in_valid || results_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [irpd_pkg::CFG_INDEX_W-1:0] idx, stamp_t value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    task automatic load_windows(irpd_pkg::irpd_windows_t w);
        write_reg(irpd_pkg::REG_START_MIN, w.start_min);
        write_reg(irpd_pkg::REG_START_MAX, w.start_max);
        write_reg(irpd_pkg::REG_ZERO_MIN, w.zero_min);
        write_reg(irpd_pkg::REG_ZERO_MAX, w.zero_max);
        write_reg(irpd_pkg::REG_ONE_MIN, w.one_min);
        write_reg(irpd_pkg::REG_ONE_MAX, w.one_max);
        @(posedge clk);
        cfg_we <= 1'b0;
        win = w;
    endtask

    // mostly well-formed frames, some cut short, some stray edges
    task automatic add_traffic(int unsigned count);
        int unsigned added;
        int unsigned roll;
        int unsigned k;
        added = 0;
        while (added < count)
        begin
            roll = $urandom_range(99);
            if (roll < 80)
            begin
                queue_gap(pick(win.start_min, win.start_max));
                added++;
                k = (roll < 68) ? FRAME_BITS : $urandom_range(FRAME_BITS - 1);
                repeat (k)
                begin
                    if ($urandom_range(1))
                        queue_gap(pick(win.one_min, win.one_max));
                    else
                        queue_gap(pick(win.zero_min, win.zero_max));
                    added++;
                end
                if (k < FRAME_BITS)
                begin
                    queue_gap(stamp_t'($urandom_range(16'hFFFF)));
                    added++;
                end
            end
            else if (roll < 90)
            begin
                if ($urandom_range(1))
                    queue_gap(pick(win.one_min, win.one_max));
                else
                    queue_gap(pick(win.zero_min, win.zero_max));
                added++;
            end
            else if (roll < 95)
            begin
                queue_gap(stamp_t'($urandom_range(16'hFFFF)));
                added++;
            end
            else
            begin
                queue_stamp(stamp_t'($urandom_range(16'hFFFF)));
                added++;
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // first edge measured from zero, then a clean frame 1011_0010
        queue_stamp(16'd0);
        queue_gap(16'd60000);
        queue_gap(16'd36000);
        queue_gap(16'd24000);
        queue_gap(16'd36000);
        queue_gap(16'd36000);
        queue_gap(16'd24000);
        queue_gap(16'd24000);
        queue_gap(16'd36000);
        queue_gap(16'd24000);
        // stray bit after the frame closed
        queue_gap(16'd24000);
        // window edges, then an error in mid-frame and a bit after it
        queue_gap(16'd56000);
        queue_gap(16'd40000);
        queue_gap(16'd20000);
        queue_gap(16'd28000);
        queue_gap(16'd19999);
        queue_gap(16'd32000);
        // top stamp and wrap of the interval
        queue_stamp(16'hFFFF);
        queue_gap(16'd64000);
        queue_gap(16'd64001);
        queue_gap(16'd31999);
        queue_gap(16'd40001);
        queue_gap(16'd55999);
        queue_gap(16'hFFFF);
        queue_gap(16'd0);
        drain();

        add_traffic(120);
        drain();
        // sender held until the decoder is empty, then more of the same
        add_traffic(80);
        drain();

        // overlapping windows: first match wins
        load_windows('{16'd30000, 16'd35000, 16'd20000, 16'd40000, 16'd10000, 16'd50000});
        add_traffic(140);
        drain();

        // register extremes: start only at the top, zero only at zero
        load_windows('{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 16'hFFFE});
        add_traffic(120);
        drain();

        // empty zero window, start at the bottom and one at the top, the range between them an error
        load_windows('{16'h0000, 16'd1000, 16'd5000, 16'd4000, 16'd40000, 16'hFFFF});
        add_traffic(110);
        drain();

        // back to defaults, no idling on either side
        idle_pct = 0;
        load_windows('{irpd_pkg::START_MIN_RESET, irpd_pkg::START_MAX_RESET,
                       irpd_pkg::ZERO_MIN_RESET, irpd_pkg::ZERO_MAX_RESET,
                       irpd_pkg::ONE_MIN_RESET, irpd_pkg::ONE_MAX_RESET});
        add_traffic(180);
        drain();

        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
